// ===== sv/chj_pkg.sv =====
// Shared constants and types for the chained hash join table.
package chj_pkg;

  localparam int BUCKETS = 1024;
  localparam int ENTRIES = 1024;
  localparam int BKT_W   = $clog2(BUCKETS);
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int LINK_W  = $clog2(ENTRIES + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_JOIN_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NULL_EQUAL = 2'd1;

  localparam logic [2:0] MODE_INNER = 3'd0;
  localparam logic [2:0] MODE_LEFT  = 3'd1;
  localparam logic [2:0] MODE_SEMI  = 3'd2;
  localparam logic [2:0] MODE_ANTI  = 3'd3;
  localparam logic [2:0] MODE_MARK  = 3'd4;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_PROBE  = 2'd1;
  localparam logic [1:0] OP_NEXT   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NO_PROBE = 2'd2;

  typedef struct packed {
    logic [31:0]       key;
    logic              key_null;
    logic [31:0]       payload;
    logic [LINK_W-1:0] next;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic        row_valid;
    logic [31:0] out_payload;
    logic        payload_null;
    logic        matched;
    logic        mark_null;
    logic        more;
    logic [1:0]  status;
  } result_t;

endpackage

// ===== sv/chj_if.sv =====
// Handshake interfaces: request word, result word and configuration write.
interface chj_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] hash;
  logic [31:0] key;
  logic        key_null;
  logic [31:0] payload;
  modport source (output valid, operation, hash, key, key_null, payload, input ready);
  modport sink   (input valid, operation, hash, key, key_null, payload, output ready);
endinterface

interface chj_rsp_if;
  logic        valid;
  logic        ready;
  logic        row_valid;
  logic [31:0] out_payload;
  logic        payload_null;
  logic        matched;
  logic        mark_null;
  logic        more;
  logic [1:0]  status;
  modport source (output valid, row_valid, out_payload, payload_null, matched, mark_null,
                  more, status, input ready);
  modport sink   (input valid, row_valid, out_payload, payload_null, matched, mark_null,
                  more, status, output ready);
endinterface

interface chj_cfg_if;
  import chj_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/chj_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module chj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== sv/chained_hash_join_table_unit.sv =====
// Chained hash join table: bucket heads and entry chains kept in block RAM.
//
// After reset the bucket-head RAM is cleared one bucket per cycle (all
// BUCKETS buckets, 1024 here); no request word is taken during that pass,
// config writes are. Requests are handled one at a time. An insert steps
// through accept, bucket read + entry and head write, result load. A probe
// or next reads chain entries until a match or the chain end (a null probe
// with nulls distinct reads no entry). Each entry read is a RAM read state
// (S_WALK) plus a compare state (S_ENTRY), and the chain end costs another
// check in S_WALK. A next without an active probe and an unused operation
// go from the head state straight to result load. The result sits in an
// output register, so one result may wait while the next request is already
// being worked on; a second finished result holds the unit in its done
// state until that register frees. Inner/left probe and next return one row
// per word; semi/anti/mark return one verdict per probe. Join modes 5..7
// act as inner.
module chained_hash_join_table_unit (
  input logic clk,
  input logic rst,
  chj_req_if.sink   req,
  chj_rsp_if.source rsp,
  chj_cfg_if.sink   cfg
);
  import chj_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HEAD  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_ENTRY = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state, state_next;

  // config registers
  logic [2:0] join_mode;
  logic       null_equal;

  // latched request word
  logic [1:0]       op_q;
  logic [BKT_W-1:0] bkt_q;
  logic [31:0]      key_q;
  logic             knull_q;
  logic [31:0]      pay_q;

  // table and probe state
  logic [BKT_W-1:0]  clr_cnt, clr_cnt_next;
  logic [LINK_W-1:0] total, total_next;
  logic              saw_null, saw_null_next;
  logic [LINK_W-1:0] cursor, cursor_next;
  logic [LINK_W-1:0] steps, steps_next;
  logic [31:0]       pkey, pkey_next;
  logic              pnull, pnull_next;
  logic              active, active_next;
  result_t           res, res_next;
  result_t           out_q;
  logic              out_valid;

  // RAM ports
  logic              bh_we;
  logic [BKT_W-1:0]  bh_waddr, bh_raddr;
  logic [LINK_W-1:0] bh_wdata, bh_rdata;
  logic              en_we;
  logic [IDX_W-1:0]  en_waddr, en_raddr;
  entry_t            en_wdata, en_rdata;

  // walk end bookkeeping
  logic              walk_end, found, ent_match;
  logic [31:0]       hit_payload;
  logic [LINK_W-1:0] cur_after;

  chj_ram #(.WIDTH(LINK_W), .DEPTH(BUCKETS)) u_heads (
    .clk(clk), .wr_en(bh_we), .wr_addr(bh_waddr), .wr_data(bh_wdata),
    .rd_addr(bh_raddr), .rd_data(bh_rdata)
  );

  chj_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_entries (
    .clk(clk), .wr_en(en_we), .wr_addr(en_waddr), .wr_data(en_wdata),
    .rd_addr(en_raddr), .rd_data(en_rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign rsp.valid        = out_valid;
  assign rsp.row_valid    = out_q.row_valid;
  assign rsp.out_payload  = out_q.out_payload;
  assign rsp.payload_null = out_q.payload_null;
  assign rsp.matched      = out_q.matched;
  assign rsp.mark_null    = out_q.mark_null;
  assign rsp.more         = out_q.more;
  assign rsp.status       = out_q.status;

  // null keys only meet each other, and only when nulls compare equal
  always_comb begin
    if (en_rdata.key_null || pnull) begin
      ent_match = en_rdata.key_null && pnull && null_equal;
    end else begin
      ent_match = (en_rdata.key == pkey);
    end
  end

  always_comb begin
    state_next    = state;
    clr_cnt_next  = clr_cnt;
    total_next    = total;
    saw_null_next = saw_null;
    cursor_next   = cursor;
    steps_next    = steps;
    pkey_next     = pkey;
    pnull_next    = pnull;
    active_next   = active;
    res_next      = res;
    bh_we         = 1'b0;
    bh_waddr      = clr_cnt;
    bh_wdata      = '0;
    bh_raddr      = req.hash[BKT_W-1:0];
    en_we         = 1'b0;
    en_waddr      = total[IDX_W-1:0];
    en_wdata      = '{key: key_q, key_null: knull_q, payload: pay_q, next: bh_rdata};
    en_raddr      = IDX_W'(cursor - LINK_W'(1));
    walk_end      = 1'b0;
    found         = 1'b0;
    hit_payload   = '0;
    cur_after     = cursor;

    case (state)
      S_CLEAR: begin
        bh_we        = 1'b1;
        clr_cnt_next = clr_cnt + BKT_W'(1);
        if (clr_cnt == BKT_W'(BUCKETS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) state_next = S_HEAD;
      end
      S_HEAD: begin
        res_next = '0;
        case (op_q)
          OP_INSERT: begin
            state_next = S_DONE;
            if (knull_q && !null_equal) begin
              saw_null_next = 1'b1;
            end else if (total >= LINK_W'(ENTRIES)) begin
              res_next.status = ST_FULL;
            end else begin
              // prepend: new entry links to old head, head points at it
              en_we      = 1'b1;
              bh_we      = 1'b1;
              bh_waddr   = bkt_q;
              bh_wdata   = total + LINK_W'(1);
              total_next = total + LINK_W'(1);
            end
          end
          OP_PROBE: begin
            pkey_next   = key_q;
            pnull_next  = knull_q;
            active_next = 1'b0;
            cursor_next = (knull_q && !null_equal) ? '0 : bh_rdata;
            steps_next  = '0;
            state_next  = S_WALK;
          end
          OP_NEXT: begin
            if (!active) begin
              res_next.status = ST_NO_PROBE;
              state_next      = S_DONE;
            end else begin
              steps_next = '0;
              state_next = S_WALK;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_WALK: begin
        if (cursor == '0 || steps >= LINK_W'(ENTRIES) || cursor > LINK_W'(ENTRIES)) begin
          walk_end  = 1'b1;
          cur_after = (cursor > LINK_W'(ENTRIES)) ? '0 : cursor;
        end else begin
          state_next = S_ENTRY;
        end
      end
      S_ENTRY: begin
        cursor_next = en_rdata.next;
        steps_next  = steps + LINK_W'(1);
        if (ent_match) begin
          walk_end    = 1'b1;
          found       = 1'b1;
          hit_payload = en_rdata.payload;
          cur_after   = en_rdata.next;
        end else begin
          state_next = S_WALK;
        end
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase

    if (walk_end) begin
      state_next  = S_DONE;
      cursor_next = cur_after;
      if (op_q == OP_PROBE && (join_mode inside {MODE_SEMI, MODE_ANTI, MODE_MARK})) begin
        // verdict modes: one answer, probe closes
        res_next.row_valid = 1'b1;
        res_next.matched   = found;
        res_next.mark_null = (join_mode == MODE_MARK) && !found &&
                             ((pnull && !null_equal) || saw_null);
        cursor_next = '0;
        active_next = 1'b0;
      end else if (found) begin
        res_next.row_valid   = 1'b1;
        res_next.out_payload = hit_payload;
        res_next.more        = (cur_after != '0);
        active_next          = (cur_after != '0);
      end else begin
        active_next = 1'b0;
        if (op_q == OP_PROBE && join_mode == MODE_LEFT) begin
          res_next.row_valid    = 1'b1;
          res_next.payload_null = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      total      <= '0;
      saw_null   <= 1'b0;
      cursor     <= '0;
      steps      <= '0;
      pkey       <= '0;
      pnull      <= 1'b0;
      active     <= 1'b0;
      out_valid  <= 1'b0;
      join_mode  <= MODE_INNER;
      null_equal <= 1'b0;
    end else begin
      state    <= state_next;
      clr_cnt  <= clr_cnt_next;
      total    <= total_next;
      saw_null <= saw_null_next;
      cursor   <= cursor_next;
      steps    <= steps_next;
      pkey     <= pkey_next;
      pnull    <= pnull_next;
      active   <= active_next;
      if (state == S_DONE && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid) begin
        case (cfg.index)
          CFG_JOIN_MODE:  join_mode  <= cfg.data;
          CFG_NULL_EQUAL: null_equal <= cfg.data[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    res <= res_next;
    if (state == S_DONE && (!out_valid || rsp.ready)) out_q <= res;
    if (req.valid && req.ready) begin
      op_q    <= req.operation;
      bkt_q   <= req.hash[BKT_W-1:0];
      key_q   <= req.key;
      knull_q <= req.key_null;
      pay_q   <= req.payload;
    end
  end

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= LINK_W'(ENTRIES))
    else $error("entry count past capacity");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_q.status == ST_FULL) |-> (total == LINK_W'(ENTRIES)))
    else $error("table-full status while room remains");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second word taken while one is in work");
`endif

endmodule

// ===== bench/chj_tb_if.sv =====
`timescale 1ns / 100ps
// Bench package: the request word type used by the stimulus.
package chj_tb_pkg;
  import chj_pkg::*;

  typedef struct {
    logic [1:0]  operation;
    logic [31:0] hash;
    logic [31:0] key;
    logic        key_null;
    logic [31:0] payload;
  } req_word_t;
endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the chained hash join table: directed table, mode sweeps, random traffic, fill to overflow.
module tb_top;
  import chj_pkg::*;
  import chj_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  chj_req_if req ();
  chj_rsp_if rsp ();
  chj_cfg_if cfg ();

  chained_hash_join_table_unit dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the table.
  logic [LINK_W-1:0] shd_head [BUCKETS];
  logic [31:0]       shd_key  [ENTRIES];
  logic [31:0]       shd_pay  [ENTRIES];
  logic [LINK_W-1:0] shd_next [ENTRIES];
  logic              shd_null [ENTRIES];
  int unsigned       shd_total;
  logic              shd_saw_null;
  logic [LINK_W-1:0] shd_cursor;
  logic [31:0]       shd_pkey;
  logic              shd_pnull;
  logic              shd_found;
  logic              shd_active;
  logic [2:0]        shd_mode;
  logic              shd_null_eq;

  result_t expected_rows [$];
  int      fail_count = 0;

  function automatic bit entry_hit(int unsigned e);
    if (shd_null[e] || shd_pnull) return shd_null[e] && shd_pnull && shd_null_eq;
    return shd_key[e] == shd_pkey;
  endfunction

  // Walks from the cursor to the next matching entry.
  function automatic bit chain_walk(output int unsigned hit);
    int unsigned steps;
    int unsigned e;
    steps = 0;
    hit = 0;
    while (shd_cursor != 0 && steps < ENTRIES) begin
      e = shd_cursor - 1;
      shd_cursor = shd_next[e];
      steps++;
      if (entry_hit(e)) begin
        hit = e;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void row_from_chain(inout result_t r);
    int unsigned hit;
    if (chain_walk(hit)) begin
      shd_found = 1'b1;
      r.row_valid = 1'b1;
      r.out_payload = shd_pay[hit];
      r.more = shd_cursor != 0;
      shd_active = shd_cursor != 0;
    end else begin
      shd_active = 1'b0;
    end
  endfunction

  function automatic result_t predict_join(req_word_t w);
    result_t     r;
    int unsigned bkt;
    int unsigned hit;
    bit          found;
    r = '0;
    bkt = w.hash & (BUCKETS - 1);
    case (w.operation)
      OP_INSERT: begin
        if (w.key_null && !shd_null_eq) shd_saw_null = 1'b1;
        else if (shd_total >= ENTRIES) r.status = ST_FULL;
        else begin
          shd_key[shd_total]  = w.key;
          shd_pay[shd_total]  = w.payload;
          shd_null[shd_total] = w.key_null;
          shd_next[shd_total] = shd_head[bkt];
          shd_head[bkt] = LINK_W'(shd_total + 1);
          shd_total++;
        end
      end
      OP_PROBE: begin
        shd_pkey = w.key;
        shd_pnull = w.key_null;
        shd_found = 1'b0;
        shd_active = 1'b0;
        shd_cursor = (w.key_null && !shd_null_eq) ? '0 : shd_head[bkt];
        if (shd_mode == MODE_SEMI || shd_mode == MODE_ANTI || shd_mode == MODE_MARK) begin
          found = chain_walk(hit);
          shd_found = found;
          shd_cursor = '0;
          r.row_valid = 1'b1;
          r.matched = found;
          r.mark_null = shd_mode == MODE_MARK && !found &&
                        ((w.key_null && !shd_null_eq) || shd_saw_null);
        end else begin
          row_from_chain(r);
          if (shd_mode == MODE_LEFT && !shd_found) begin
            r.row_valid = 1'b1;
            r.payload_null = 1'b1;
          end
        end
      end
      OP_NEXT: begin
        if (!shd_active) r.status = ST_NO_PROBE;
        else row_from_chain(r);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    if (idx == CFG_JOIN_MODE) shd_mode = val;
    else shd_null_eq = val[0];
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Sends one word; the expectation is queued at the accepting edge.
  // Valid stays up after the accept; the next word's idle gap or drain lowers it.
  task automatic send_word(req_word_t w, bit typed, result_t typed_row);
    result_t     r;
    int unsigned idle;
    idle = $urandom_range(0, 4);
    @(negedge clk);
    if (idle != 0) begin
      req.valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= w.operation;
    req.hash <= w.hash;
    req.key <= w.key;
    req.key_null <= w.key_null;
    req.payload <= w.payload;
    do @(posedge clk); while (!req.ready);
    r = predict_join(w);
    if (typed) r = typed_row;
    expected_rows = {expected_rows, r};
  endtask

  task automatic drain;
    @(negedge clk);
    req.valid <= 1'b0;
    while (expected_rows.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  // Result-side ready: random stall per word.
  initial begin
    int unsigned stall;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = $urandom_range(0, 4);
      if (stall != 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_rows.size() == 0) begin
        $error("unexpected result word");
        fail_count++;
      end else begin
        want = expected_rows.pop_front();
        if (rsp.row_valid !== want.row_valid) begin
          $error("row_valid exp %0d act %0d", want.row_valid, rsp.row_valid); fail_count++;
        end
        if (rsp.out_payload !== want.out_payload) begin
          $error("out_payload exp %h act %h", want.out_payload, rsp.out_payload); fail_count++;
        end
        if (rsp.payload_null !== want.payload_null) begin
          $error("payload_null exp %0d act %0d", want.payload_null, rsp.payload_null);
          fail_count++;
        end
        if (rsp.matched !== want.matched) begin
          $error("matched exp %0d act %0d", want.matched, rsp.matched); fail_count++;
        end
        if (rsp.mark_null !== want.mark_null) begin
          $error("mark_null exp %0d act %0d", want.mark_null, rsp.mark_null); fail_count++;
        end
        if (rsp.more !== want.more) begin
          $error("more exp %0d act %0d", want.more, rsp.more); fail_count++;
        end
        if (rsp.status !== want.status) begin
          $error("status exp %0d act %0d", want.status, rsp.status); fail_count++;
        end
      end
    end
  end

  typedef struct {
    req_word_t w;
    bit        typed;
    result_t   row;
  } dir_row_t;

  function automatic dir_row_t mk(logic [1:0] op, logic [31:0] h, logic [31:0] k,
                                  logic kn, logic [31:0] p, bit typed = 1'b0,
                                  result_t row = '0);
    dir_row_t d;
    d.w = '{op, h, k, kn, p};
    d.typed = typed;
    d.row = row;
    return d;
  endfunction

  // Random word; keys drawn from a small pool so that probes hit.
  function automatic req_word_t rand_word();
    req_word_t w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    w.operation = pick < 40 ? OP_INSERT : pick < 70 ? OP_PROBE : pick < 97 ? OP_NEXT :
                  OP_UNUSED;
    w.key = $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 7);
    w.hash = $urandom_range(0, 3) == 0 ? $urandom() : (w.key * 3) & 32'hF;
    if ($urandom_range(0, 1)) w.hash = w.hash | ($urandom() & 32'hFFFF_FC00);
    w.key_null = $urandom_range(0, 9) == 0;
    w.payload = $urandom();
    return w;
  endfunction

  initial begin : stimulus
    dir_row_t    dir [$];
    result_t     row;
    req_word_t   w;
    logic [2:0]  mode_set [6];
    int unsigned phase;
    req.valid = 1'b0; req.operation = '0; req.hash = '0; req.key = '0;
    req.key_null = 1'b0; req.payload = '0;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    foreach (shd_head[i]) shd_head[i] = '0;
    shd_total = 0; shd_saw_null = 0; shd_cursor = '0; shd_pkey = '0; shd_pnull = 0;
    shd_found = 0; shd_active = 0; shd_mode = MODE_INNER; shd_null_eq = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: next with no probe, an empty-table probe, extremes, unused op.
    row = '0; row.status = ST_NO_PROBE;
    dir = {dir, mk(OP_NEXT, '0, '0, 1'b0, '0, 1'b1, row)};
    dir = {dir, mk(OP_PROBE, '0, '0, 1'b0, '0, 1'b1, '0)};
    dir = {dir, mk(OP_UNUSED, '1, '1, 1'b1, '1, 1'b1, '0)};
    dir = {dir, mk(OP_INSERT, 32'h0, 32'h0, 1'b0, 32'h0)};
    dir = {dir, mk(OP_INSERT, 32'hFFFF_FC00, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF)};
    dir = {dir, mk(OP_INSERT, 32'h0, 32'h0, 1'b0, 32'h1234_5678)};
    dir = {dir, mk(OP_INSERT, '1, 32'h5, 1'b1, 32'hAAAA_5555, 1'b1, '0)};
    dir = {dir, mk(OP_PROBE, 32'h0, 32'h0, 1'b0, '0)};
    dir = {dir, mk(OP_NEXT, '0, '0, 1'b0, '0)};
    dir = {dir, mk(OP_NEXT, '0, '0, 1'b0, '0)};
    dir = {dir, mk(OP_PROBE, 32'hFFFF_FC00, 32'hFFFF_FFFF, 1'b0, '0)};
    dir = {dir, mk(OP_PROBE, '1, '0, 1'b1, '0)};
    foreach (dir[i]) send_word(dir[i].w, dir[i].typed, dir[i].row);
    drain();
    // Left, each verdict mode, mode 7 and inner, null-equal toggled, on one growing table.
    mode_set = '{MODE_LEFT, MODE_SEMI, MODE_ANTI, MODE_MARK, 3'd7, MODE_INNER};
    foreach (mode_set[m]) begin
      write_reg(CFG_JOIN_MODE, mode_set[m]);
      write_reg(CFG_NULL_EQUAL, CFG_DATA_W'(m % 2));
      send_word('{OP_INSERT, 32'h3FF, 32'h9, 1'(m % 2), 32'h77}, 1'b0, '0);
      send_word('{OP_PROBE, 32'h3FF, 32'h9, 1'b1, '0}, 1'b0, '0);
      send_word('{OP_PROBE, 32'h3FF, 32'h8, 1'b0, '0}, 1'b0, '0);
      send_word('{OP_PROBE, 32'h0, 32'h0, 1'b0, '0}, 1'b0, '0);
      send_word('{OP_NEXT, '0, '0, 1'b0, '0}, 1'b0, '0);
      drain();
    end

    // Random phases, then fill the table to overflow.
    for (phase = 0; phase < 8; phase++) begin
      write_reg(CFG_JOIN_MODE, CFG_DATA_W'($urandom_range(0, 7)));
      write_reg(CFG_NULL_EQUAL, CFG_DATA_W'($urandom_range(0, 1)));
      repeat (30) begin
        w = rand_word();
        send_word(w, 1'b0, '0);
      end
      drain();
    end
    while (shd_total < ENTRIES) begin
      w = rand_word();
      w.operation = OP_INSERT; w.key_null = 1'b0;
      send_word(w, 1'b0, '0);
    end
    row = '0; row.status = ST_FULL;
    send_word('{OP_INSERT, '1, '1, 1'b0, '1}, 1'b1, row);
    drain();
    write_reg(CFG_JOIN_MODE, MODE_MARK);
    repeat (60) begin
      w = rand_word();
      send_word(w, 1'b0, '0);
    end
    drain();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Slowest run: ~1300 words, each with at worst a full chain walk plus stalls.
  initial begin
    #80ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
sv/chj_pkg.sv
sv/chj_if.sv
sv/chj_ram.sv
sv/chained_hash_join_table_unit.sv
bench/chj_tb_if.sv
bench/tb_top.sv
